// ----- hdl/jdd_pkg.sv -----
// Shared types and constants of the joystick direction event decoder.
package jdd_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned LevelW   = 11;
  localparam int unsigned DirW     = 3;
  localparam int unsigned RegSlots = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [SampleW-1:0] CenterVal   = 10'd512;
  localparam logic [SampleW-1:0] FullScale   = 10'd1023;
  localparam logic [SampleW-1:0] ThreshReset = 10'd150;

  typedef enum logic [DirW-1:0] {
    DIR_CENTER = 3'd0,
    DIR_UP     = 3'd1,
    DIR_DOWN   = 3'd2,
    DIR_LEFT   = 3'd3,
    DIR_RIGHT  = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    REG_DIR_THRESHOLD = 3'd0,
    REG_DEAD_ZONE     = 3'd1,
    REG_X_LEVEL_A     = 3'd2,
    REG_X_LEVEL_B     = 3'd3,
    REG_Y_LEVEL_A     = 3'd4,
    REG_Y_LEVEL_B     = 3'd5,
    REG_LEVEL_ENABLE  = 3'd6,
    REG_NONE          = 3'd7
  } reg_e;

  typedef struct packed {
    logic [SampleW-1:0]                  dir_threshold;
    logic [SampleW-1:0]                  dead_zone;
    logic [RegSlots-1:0][LevelW-1:0]     level;
    logic [RegSlots-1:0]                 level_enable;
  } cfg_t;

  // Declared from the highest field down so that y_value sits in the lowest bits.
  typedef struct packed {
    logic [RegSlots-1:0] neg_uncrossed;
    logic [RegSlots-1:0] neg_crossed;
    logic [RegSlots-1:0] pos_uncrossed;
    logic [RegSlots-1:0] pos_crossed;
    logic                moved;
    dir_e                exited_dir;
    dir_e                entered_dir;
    dir_e                direction;
    logic [SampleW-1:0]  y_value;
  } result_t;

endpackage

// ----- hdl/jdd_regs.sv -----
// Configuration register file behind the APB-style port.
module jdd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [jdd_pkg::AddrW-1:0]   paddr_i,
  input  logic [jdd_pkg::DataW-1:0]   pwdata_i,
  output logic [jdd_pkg::DataW-1:0]   prdata_o,
  output logic                        pready_o,
  output jdd_pkg::cfg_t               cfg_o
);

  jdd_pkg::cfg_t cfg_q;
  jdd_pkg::reg_e sel;
  logic          wr_en;

  assign pready_o = 1'b1;
  assign sel      = jdd_pkg::reg_e'(paddr_i[jdd_pkg::AddrW-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_threshold <= jdd_pkg::ThreshReset;
      cfg_q.dead_zone     <= '0;
      cfg_q.level         <= '0;
      cfg_q.level_enable  <= '0;
    end else if (wr_en) begin
      unique case (sel)
        jdd_pkg::REG_DIR_THRESHOLD:
          cfg_q.dir_threshold <= pwdata_i[jdd_pkg::SampleW-1:0];
        jdd_pkg::REG_DEAD_ZONE:
          cfg_q.dead_zone <= pwdata_i[jdd_pkg::SampleW-1:0];
        jdd_pkg::REG_X_LEVEL_A: cfg_q.level[0] <= pwdata_i[jdd_pkg::LevelW-1:0];
        jdd_pkg::REG_X_LEVEL_B: cfg_q.level[1] <= pwdata_i[jdd_pkg::LevelW-1:0];
        jdd_pkg::REG_Y_LEVEL_A: cfg_q.level[2] <= pwdata_i[jdd_pkg::LevelW-1:0];
        jdd_pkg::REG_Y_LEVEL_B: cfg_q.level[3] <= pwdata_i[jdd_pkg::LevelW-1:0];
        jdd_pkg::REG_LEVEL_ENABLE:
          cfg_q.level_enable <= pwdata_i[jdd_pkg::RegSlots-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (sel)
      jdd_pkg::REG_DIR_THRESHOLD:
        prdata_o[jdd_pkg::SampleW-1:0] = cfg_q.dir_threshold;
      jdd_pkg::REG_DEAD_ZONE:
        prdata_o[jdd_pkg::SampleW-1:0] = cfg_q.dead_zone;
      jdd_pkg::REG_X_LEVEL_A: prdata_o[jdd_pkg::LevelW-1:0] = cfg_q.level[0];
      jdd_pkg::REG_X_LEVEL_B: prdata_o[jdd_pkg::LevelW-1:0] = cfg_q.level[1];
      jdd_pkg::REG_Y_LEVEL_A: prdata_o[jdd_pkg::LevelW-1:0] = cfg_q.level[2];
      jdd_pkg::REG_Y_LEVEL_B: prdata_o[jdd_pkg::LevelW-1:0] = cfg_q.level[3];
      jdd_pkg::REG_LEVEL_ENABLE:
        prdata_o[jdd_pkg::RegSlots-1:0] = cfg_q.level_enable;
      default: prdata_o = '0;
    endcase
  end

endmodule

// ----- hdl/jdd_eval.sv -----
// Combinational decode of one sample pair against the previous sample.
module jdd_eval #(
  parameter int unsigned LEVEL_SLOTS = 4
) (
  input  logic [jdd_pkg::SampleW-1:0] raw_x_i,
  input  logic [jdd_pkg::SampleW-1:0] raw_y_i,
  input  logic [jdd_pkg::SampleW-1:0] last_x_i,
  input  logic [jdd_pkg::SampleW-1:0] last_y_i,
  input  jdd_pkg::dir_e               last_dir_i,
  input  jdd_pkg::cfg_t               cfg_i,
  output jdd_pkg::result_t            result_o
);

  localparam int unsigned CmpW = jdd_pkg::LevelW + 2;

  logic [jdd_pkg::SampleW-1:0] cx, cy;
  logic signed [jdd_pkg::SampleW:0] dx, dy;
  logic [jdd_pkg::SampleW-1:0] ax, ay;
  jdd_pkg::dir_e dir;

  assign cx = raw_x_i;
  assign cy = jdd_pkg::FullScale - raw_y_i;
  assign dx = $signed({1'b0, cx}) - $signed({1'b0, jdd_pkg::CenterVal});
  assign dy = $signed({1'b0, cy}) - $signed({1'b0, jdd_pkg::CenterVal});
  // Magnitude tops out at 512, so ten bits hold it.
  assign ax = dx[jdd_pkg::SampleW] ? jdd_pkg::SampleW'(-dx) : dx[jdd_pkg::SampleW-1:0];
  assign ay = dy[jdd_pkg::SampleW] ? jdd_pkg::SampleW'(-dy) : dy[jdd_pkg::SampleW-1:0];

  always_comb begin
    if (ax < cfg_i.dir_threshold && ay < cfg_i.dir_threshold) begin
      dir = jdd_pkg::DIR_CENTER;
    end else if (ax > ay) begin
      dir = (!dx[jdd_pkg::SampleW] && dx != '0) ? jdd_pkg::DIR_RIGHT : jdd_pkg::DIR_LEFT;
    end else begin
      dir = (!dy[jdd_pkg::SampleW] && dy != '0) ? jdd_pkg::DIR_DOWN : jdd_pkg::DIR_UP;
    end
  end

  always_comb begin
    logic signed [CmpW-1:0] lvl, nlvl, pv, cv;
    logic pp, cp, pn, cn;
    result_o             = '0;
    result_o.y_value     = cy;
    result_o.direction   = dir;
    result_o.entered_dir = jdd_pkg::DIR_CENTER;
    result_o.exited_dir  = jdd_pkg::DIR_CENTER;
    if (dir != last_dir_i) begin
      result_o.entered_dir = dir;
      result_o.exited_dir  = last_dir_i;
    end
    result_o.moved = (ax > cfg_i.dead_zone) || (ay > cfg_i.dead_zone);
    for (int i = 0; i < jdd_pkg::RegSlots; i++) begin
      lvl  = CmpW'($signed(cfg_i.level[i]));
      nlvl = -lvl;
      // Slots zero and one watch X, the rest watch inverted Y.
      pv   = (i < 2) ? $signed(CmpW'(last_x_i)) : $signed(CmpW'(last_y_i));
      cv   = (i < 2) ? $signed(CmpW'(cx)) : $signed(CmpW'(cy));
      pp   = pv >= lvl;
      cp   = cv >= lvl;
      pn   = pv <= nlvl;
      cn   = cv <= nlvl;
      if (i < LEVEL_SLOTS && cfg_i.level_enable[i]) begin
        result_o.pos_crossed[i]   = !pp && cp;
        result_o.pos_uncrossed[i] = pp && !cp;
        result_o.neg_crossed[i]   = !pn && cn;
        result_o.neg_uncrossed[i] = pn && !cn;
      end
    end
  end

endmodule

// ----- hdl/joystick_direction_event_decoder.sv -----
// Top level: input register, decode, result register and previous-sample state.
// An accepted item is held in the input register, decoded from there, and presented on the
// output once it moves into the result register, where it stays until taken.
// Throughput: one item per cycle unless the output stalls; the input and result registers
// form a two-stage pipeline that advances whenever the result register is empty or taken.
// The previous X, Y and direction update as an item moves into the result register.
// Reset (rst_ni low, asynchronous): both stages empty, previous X and Y at 512,
// previous direction center, threshold 150, dead zone, levels and enables zero.
module joystick_direction_event_decoder #(
  parameter int unsigned LEVEL_SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Sample items in.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: raw_x[9:0], raw_y[19:10], zero[23:20]
  input  logic [23:0]                 s_axis_tdata_i,
  // Result items out.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // tdata: y_value[9:0], direction[12:10], entered_dir[15:13], exited_dir[18:16],
  //        moved[19], pos_crossed[23:20], pos_uncrossed[27:24], neg_crossed[31:28],
  //        neg_uncrossed[35:32], zero[39:36]
  output logic [39:0]                 m_axis_tdata_o,
  // Configuration port.
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [jdd_pkg::AddrW-1:0]   paddr_i,
  input  logic [jdd_pkg::DataW-1:0]   pwdata_i,
  output logic [jdd_pkg::DataW-1:0]   prdata_o,
  output logic                        pready_o
);

  jdd_pkg::cfg_t    cfg;
  jdd_pkg::result_t result;

  logic                        in_valid_q;
  logic [jdd_pkg::SampleW-1:0] in_x_q, in_y_q;
  logic                        out_valid_q;
  jdd_pkg::result_t            out_q;
  logic [jdd_pkg::SampleW-1:0] last_x_q, last_y_q;
  jdd_pkg::dir_e               last_dir_q;

  logic out_free, advance, accept;

  // Result register frees up when empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  jdd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  jdd_eval #(
    .LEVEL_SLOTS (LEVEL_SLOTS)
  ) u_eval (
    .raw_x_i    (in_x_q),
    .raw_y_i    (in_y_q),
    .last_x_i   (last_x_q),
    .last_y_i   (last_y_q),
    .last_dir_i (last_dir_q),
    .cfg_i      (cfg),
    .result_o   (result)
  );

  // Control: stage valid flags and previous-sample state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_x_q    <= jdd_pkg::CenterVal;
      last_y_q    <= jdd_pkg::CenterVal;
      last_dir_q  <= jdd_pkg::DIR_CENTER;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      // Commit the sample as its result enters the output register.
      if (advance) begin
        last_x_q   <= in_x_q;
        last_y_q   <= jdd_pkg::FullScale - in_y_q;
        last_dir_q <= result.direction;
      end
    end
  end

  // Payload: capture on accept, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_x_q <= s_axis_tdata_i[jdd_pkg::SampleW-1:0];
      in_y_q <= s_axis_tdata_i[2*jdd_pkg::SampleW-1:jdd_pkg::SampleW];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q};

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench of the joystick direction event decoder.
`timescale 1ns / 1ps

module tb;

  localparam int NumSlots = jdd_pkg::RegSlots;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    jdd_pkg::reg_e     idx;
    int                val;
    logic [9:0]        x;
    logic [9:0]        y;
    bit                typed;
    jdd_pkg::result_t  exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;

  logic        s_valid = 1'b0;
  logic [23:0] s_data = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [jdd_pkg::AddrW-1:0] paddr = '0;
  logic [jdd_pkg::DataW-1:0] pwdata = '0;
  logic [jdd_pkg::DataW-1:0] prdata;
  logic        pready;

  // Shadow copy of the configuration and of the previous-sample state.
  int          thr_q = 150;
  int          dz_q = 0;
  int          level_q [NumSlots] = '{default: 0};
  logic [3:0]  en_q = '0;
  int          prev_x = 512;
  int          prev_y = 512;
  jdd_pkg::dir_e prev_dir = jdd_pkg::DIR_CENTER;

  jdd_pkg::result_t expected_events [$];
  row_t        table_rows [$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          sample_count = 0;
  int          event_count = 0;
  int          cfg_writes = 0;
  int          dir_changes = 0;
  int          level_events = 0;
  logic [9:0]  last_raw_x = 10'd512;
  logic [9:0]  last_raw_y = 10'd511;

  joystick_direction_event_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  // Free-running clock, 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Decode one sample pair the way the block should, and advance the shadow state.
  function automatic jdd_pkg::result_t decode_sample(logic [9:0] raw_x, logic [9:0] raw_y);
    jdd_pkg::result_t r;
    int      cx, cy, dx, dy, ax, ay, lvl, pv, cv;
    bit      pp, cp, pn, cn;
    jdd_pkg::dir_e dir;
    cx = int'(raw_x);
    cy = 1023 - int'(raw_y);
    dx = cx - 512;
    dy = cy - 512;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // Center inside the threshold; otherwise the larger axis wins, ties go to Y.
    if (ax < thr_q && ay < thr_q) begin
      dir = jdd_pkg::DIR_CENTER;
    end else if (ax > ay) begin
      dir = (dx > 0) ? jdd_pkg::DIR_RIGHT : jdd_pkg::DIR_LEFT;
    end else begin
      dir = (dy > 0) ? jdd_pkg::DIR_DOWN : jdd_pkg::DIR_UP;
    end
    r = '0;
    r.y_value = 10'(cy);
    r.direction = dir;
    r.entered_dir = jdd_pkg::DIR_CENTER;
    r.exited_dir = jdd_pkg::DIR_CENTER;
    if (dir != prev_dir) begin
      r.entered_dir = dir;
      r.exited_dir = prev_dir;
    end
    r.moved = (ax > dz_q) || (ay > dz_q);
    // Slots 0 and 1 watch X, slots 2 and 3 the inverted Y; disabled slots stay quiet.
    for (int s = 0; s < NumSlots; s++) begin
      if (en_q[s]) begin
        lvl = level_q[s];
        pv = (s < 2) ? prev_x : prev_y;
        cv = (s < 2) ? cx : cy;
        pp = pv >= lvl;
        cp = cv >= lvl;
        pn = pv <= -lvl;
        cn = cv <= -lvl;
        if (!pp && cp) r.pos_crossed[s] = 1'b1;
        else if (pp && !cp) r.pos_uncrossed[s] = 1'b1;
        if (!pn && cn) r.neg_crossed[s] = 1'b1;
        else if (pn && !cn) r.neg_uncrossed[s] = 1'b1;
      end
    end
    prev_x = cx;
    prev_y = cy;
    prev_dir = dir;
    return r;
  endfunction

  function automatic row_t item_row(logic [9:0] x, logic [9:0] y);
    row_t r;
    r.kind = ROW_ITEM;
    r.idx = jdd_pkg::REG_NONE;
    r.val = 0;
    r.x = x;
    r.y = y;
    r.typed = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  // Row with its result typed in; the level masks are zero while all slots are off.
  function automatic row_t typed_row(logic [9:0] x, logic [9:0] y, int yv,
                                     jdd_pkg::dir_e d, jdd_pkg::dir_e ent,
                                     jdd_pkg::dir_e ext, logic mv);
    row_t r;
    r = item_row(x, y);
    r.typed = 1'b1;
    r.exp.y_value = 10'(yv);
    r.exp.direction = d;
    r.exp.entered_dir = ent;
    r.exp.exited_dir = ext;
    r.exp.moved = mv;
    return r;
  endfunction

  function automatic row_t cfg_row(jdd_pkg::reg_e idx, int val);
    row_t r;
    r = item_row(10'd0, 10'd0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [9:0] clamp10(int v);
    if (v < 0) return 10'd0;
    if (v > 1023) return 10'd1023;
    return 10'(v);
  endfunction

  function automatic logic [9:0] near(int target);
    return clamp10(target + int'($urandom_range(0, 8)) - 4);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Write one register over the config port: setup cycle, access cycle, idle cycle.
  // Junk above the register width must be dropped by the block.
  task automatic cfg_write(input jdd_pkg::reg_e idx, input int val);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[10:0] = val[10:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= jdd_pkg::AddrW'(int'(idx) * 4);
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_writes++;
    case (idx)
      jdd_pkg::REG_DIR_THRESHOLD: thr_q = int'(wdata[9:0]);
      jdd_pkg::REG_DEAD_ZONE:     dz_q = int'(wdata[9:0]);
      jdd_pkg::REG_X_LEVEL_A:     level_q[0] = int'($signed(wdata[10:0]));
      jdd_pkg::REG_X_LEVEL_B:     level_q[1] = int'($signed(wdata[10:0]));
      jdd_pkg::REG_Y_LEVEL_A:     level_q[2] = int'($signed(wdata[10:0]));
      jdd_pkg::REG_Y_LEVEL_B:     level_q[3] = int'($signed(wdata[10:0]));
      jdd_pkg::REG_LEVEL_ENABLE:  en_q = wdata[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  // Offer one sample item, idling first at random; log its expected result on accept.
  task automatic send_sample(input logic [9:0] x, input logic [9:0] y, input bit typed,
                             input jdd_pkg::result_t exp);
    jdd_pkg::result_t pred;
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {4'b0, y, x};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    pred = decode_sample(x, y);
    expected_events.push_back(typed ? exp : pred);
    sample_count++;
    last_raw_x = x;
    last_raw_y = y;
  endtask

  function automatic int rand_level();
    case ($urandom_range(0, 5))
      0: return 'h400;
      1: return 1023;
      2: return -1023;
      3: return int'($urandom_range(0, 1023));
      4: return -int'($urandom_range(0, 1023));
      default: return int'($urandom());
    endcase
  endfunction

  function automatic int rand_span();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1023;
      2, 3: return int'($urandom_range(0, 300));
      default: return int'($urandom());
    endcase
  endfunction

  // Load a fresh random setting into every register.
  task automatic pick_settings();
    cfg_write(jdd_pkg::REG_DIR_THRESHOLD, rand_span());
    cfg_write(jdd_pkg::REG_DEAD_ZONE, rand_span());
    cfg_write(jdd_pkg::REG_X_LEVEL_A, rand_level());
    cfg_write(jdd_pkg::REG_X_LEVEL_B, rand_level());
    cfg_write(jdd_pkg::REG_Y_LEVEL_A, rand_level());
    cfg_write(jdd_pkg::REG_Y_LEVEL_B, rand_level());
    cfg_write(jdd_pkg::REG_LEVEL_ENABLE,
              $urandom_range(0, 1) ? 15 : int'($urandom_range(0, 15)));
    if ($urandom_range(0, 3) == 0) cfg_write(jdd_pkg::REG_NONE, int'($urandom()));
  endtask

  // Choose a sample pair; half land near the threshold or a slot level so edges fire.
  task automatic pick_sample(output logic [9:0] x, output logic [9:0] y);
    int off, sgn, s;
    off = thr_q + int'($urandom_range(0, 4)) - 2;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        x = 10'($urandom());
        y = 10'($urandom());
      end
      3, 4: begin
        if ($urandom_range(0, 1)) begin
          x = clamp10(512 + sgn * off);
          y = near(511);
        end else begin
          x = near(512);
          y = clamp10(511 - sgn * off);
        end
      end
      5, 6, 7: begin
        s = $urandom_range(0, 1);
        x = near(sgn * level_q[s]);
        s = $urandom_range(2, 3);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        y = clamp10(1023 - int'(near(sgn * level_q[s])));
      end
      8: begin
        x = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 10'd0 : 10'd1023) : 10'd512;
        y = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 10'd0 : 10'd1023) : 10'd511;
      end
      default: begin
        // Repeat the last pair: no direction change, no edges.
        x = last_raw_x;
        y = last_raw_y;
      end
    endcase
  endtask

  // Result side: stall at random, check every taken item against the oldest expectation.
  initial begin
    jdd_pkg::result_t act, exp;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) begin
        act = jdd_pkg::result_t'(m_data[35:0]);
        if (expected_events.size() == 0) begin
          $error("result item with no expectation pending: %h", m_data);
          mismatches++;
        end else begin
          exp = expected_events.pop_front();
          event_count++;
          if (exp.entered_dir != exp.exited_dir) dir_changes++;
          if ({exp.pos_crossed, exp.pos_uncrossed, exp.neg_crossed, exp.neg_uncrossed} != 0)
            level_events++;
          check_field("y_value", int'(exp.y_value), int'(act.y_value));
          check_field("direction", int'(exp.direction), int'(act.direction));
          check_field("entered_dir", int'(exp.entered_dir), int'(act.entered_dir));
          check_field("exited_dir", int'(exp.exited_dir), int'(act.exited_dir));
          check_field("moved", int'(exp.moved), int'(act.moved));
          check_field("pos_crossed", int'(exp.pos_crossed), int'(act.pos_crossed));
          check_field("pos_uncrossed", int'(exp.pos_uncrossed), int'(act.pos_uncrossed));
          check_field("neg_crossed", int'(exp.neg_crossed), int'(act.neg_crossed));
          check_field("neg_uncrossed", int'(exp.neg_uncrossed), int'(act.neg_uncrossed));
        end
      end
      m_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end
  end

  // Stimulus: directed table first, then random phases with rotating idle patterns.
  initial begin
    row_t        row;
    logic [9:0]  x, y;

    // Reset settings: threshold 150, dead zone 0, all slots off.
    table_rows.push_back(typed_row(10'd512, 10'd511, 512, jdd_pkg::DIR_CENTER,
                                   jdd_pkg::DIR_CENTER, jdd_pkg::DIR_CENTER, 1'b0));
    table_rows.push_back(typed_row(10'd1023, 10'd511, 512, jdd_pkg::DIR_RIGHT,
                                   jdd_pkg::DIR_RIGHT, jdd_pkg::DIR_CENTER, 1'b1));
    table_rows.push_back(typed_row(10'd0, 10'd511, 512, jdd_pkg::DIR_LEFT,
                                   jdd_pkg::DIR_LEFT, jdd_pkg::DIR_RIGHT, 1'b1));
    table_rows.push_back(typed_row(10'd512, 10'd0, 1023, jdd_pkg::DIR_DOWN,
                                   jdd_pkg::DIR_DOWN, jdd_pkg::DIR_LEFT, 1'b1));
    table_rows.push_back(typed_row(10'd512, 10'd1023, 0, jdd_pkg::DIR_UP,
                                   jdd_pkg::DIR_UP, jdd_pkg::DIR_DOWN, 1'b1));
    // Equal offsets on both axes: Y wins.
    table_rows.push_back(typed_row(10'd1023, 10'd0, 1023, jdd_pkg::DIR_DOWN,
                                   jdd_pkg::DIR_DOWN, jdd_pkg::DIR_UP, 1'b1));
    table_rows.push_back(typed_row(10'd0, 10'd1023, 0, jdd_pkg::DIR_UP,
                                   jdd_pkg::DIR_UP, jdd_pkg::DIR_DOWN, 1'b1));
    // Just inside, then just on the threshold.
    table_rows.push_back(typed_row(10'd661, 10'd511, 512, jdd_pkg::DIR_CENTER,
                                   jdd_pkg::DIR_CENTER, jdd_pkg::DIR_UP, 1'b1));
    table_rows.push_back(typed_row(10'd662, 10'd511, 512, jdd_pkg::DIR_RIGHT,
                                   jdd_pkg::DIR_RIGHT, jdd_pkg::DIR_CENTER, 1'b1));
    // Same direction again: nothing entered or exited.
    table_rows.push_back(typed_row(10'd662, 10'd511, 512, jdd_pkg::DIR_RIGHT,
                                   jdd_pkg::DIR_CENTER, jdd_pkg::DIR_CENTER, 1'b1));
    // Zero threshold, widest dead zone, all slots on, a write to an unused address.
    table_rows.push_back(cfg_row(jdd_pkg::REG_DIR_THRESHOLD, 0));
    table_rows.push_back(cfg_row(jdd_pkg::REG_DEAD_ZONE, 1023));
    table_rows.push_back(cfg_row(jdd_pkg::REG_X_LEVEL_A, 600));
    table_rows.push_back(cfg_row(jdd_pkg::REG_X_LEVEL_B, -300));
    table_rows.push_back(cfg_row(jdd_pkg::REG_Y_LEVEL_A, 0));
    table_rows.push_back(cfg_row(jdd_pkg::REG_Y_LEVEL_B, 'h400));
    table_rows.push_back(cfg_row(jdd_pkg::REG_LEVEL_ENABLE, 15));
    table_rows.push_back(cfg_row(jdd_pkg::REG_NONE, 'h7FF));
    table_rows.push_back(item_row(10'd512, 10'd511));
    table_rows.push_back(item_row(10'd600, 10'd511));
    table_rows.push_back(item_row(10'd599, 10'd300));
    table_rows.push_back(item_row(10'd0, 10'd1023));
    table_rows.push_back(item_row(10'd1023, 10'd0));
    table_rows.push_back(item_row(10'd300, 10'd723));
    table_rows.push_back(item_row(10'd301, 10'd724));
    table_rows.push_back(item_row(10'd0, 10'd0));
    // Widest threshold, zero dead zone, extreme levels, alternate slots on.
    table_rows.push_back(cfg_row(jdd_pkg::REG_DIR_THRESHOLD, 1023));
    table_rows.push_back(cfg_row(jdd_pkg::REG_DEAD_ZONE, 0));
    table_rows.push_back(cfg_row(jdd_pkg::REG_X_LEVEL_A, 1023));
    table_rows.push_back(cfg_row(jdd_pkg::REG_X_LEVEL_B, 'h400));
    table_rows.push_back(cfg_row(jdd_pkg::REG_Y_LEVEL_A, -1023));
    table_rows.push_back(cfg_row(jdd_pkg::REG_Y_LEVEL_B, 1));
    table_rows.push_back(cfg_row(jdd_pkg::REG_LEVEL_ENABLE, 5));
    table_rows.push_back(item_row(10'd1023, 10'd0));
    table_rows.push_back(item_row(10'd0, 10'd1023));
    table_rows.push_back(item_row(10'd512, 10'd511));
    table_rows.push_back(item_row(10'd1022, 10'd1));

    wait (rst_n);
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        cfg_write(row.idx, row.val);
      end else begin
        send_sample(row.x, row.y, row.typed, row.exp);
      end
    end

    // Eight phases, each with a new setting; idle pattern rotates every phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      wait_drained();
      pick_settings();
      for (int n = 0; n < 112; n++) begin
        // Hold the sender once mid-phase until the pipeline is empty.
        if (ph == 2 && n == 56) wait_drained();
        pick_sample(x, y);
        send_sample(x, y, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d sample items, %0d results checked, %0d register writes.",
             sample_count, event_count, cfg_writes);
    $display("Results with a direction change: %0d; with a level edge: %0d.",
             dir_changes, level_events);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/jdd_pkg.sv
hdl/jdd_regs.sv
hdl/jdd_eval.sv
hdl/joystick_direction_event_decoder.sv
verif/tb.sv
